@@ hdl/armp_pkg.sv @@
// armp_pkg: shared constants, types and helper functions for the aligned range splitter
// used by armp_ctrl, armp_dp and aligned_range_to_mtrr_pairs; no dependencies
package armp_pkg;

  // range space width in 4 KiB units
  localparam int unsigned RangeAddrBits = 28;
  localparam int unsigned RemW          = RangeAddrBits + 1;

  // fixed field widths
  localparam int unsigned BaseInW  = 28;
  localparam int unsigned SizeInW  = 29;
  localparam int unsigned TypeW    = 3;
  localparam int unsigned SlotW    = 7;
  localparam int unsigned WordW    = 40;
  localparam int unsigned AbitsW   = 6;
  localparam int unsigned TotalW   = 5;
  localparam int unsigned OsResW   = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  localparam int unsigned PageShift = 12;
  localparam int unsigned MaxPieces = 2 * RangeAddrBits;
  localparam int unsigned CountW    = $clog2(MaxPieces + 1);

  localparam logic [SlotW-1:0]  SlotMax     = {SlotW{1'b1}};
  localparam logic [TotalW-1:0] SlotStore   = TotalW'(16);
  localparam logic [WordW-1:0]  MaskValid   = WordW'(12'h800);

  localparam logic [AbitsW-1:0] AbitsReset  = AbitsW'(36);
  localparam logic [TotalW-1:0] TotalReset  = TotalW'(8);
  localparam logic [OsResW-1:0] OsResReset  = '0;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAddressBits = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTotalSlots  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOsReserved  = 2'd2;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } armp_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } armp_cmd_t;

  typedef struct packed {
    logic done;
  } armp_status_t;

  // one-hot of the highest set bit
  function automatic logic [RemW-1:0] high_onehot(input logic [RemW-1:0] x);
    logic [RemW-1:0] s;
    s = x;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s & ~(s >> 1);
  endfunction

  // one-hot of the lowest set bit
  function automatic logic [RangeAddrBits-1:0] low_onehot(
    input logic [RangeAddrBits-1:0] x
  );
    return x & (~x + RangeAddrBits'(1));
  endfunction

endpackage

@@ hdl/armp_ctrl.sv @@
// armp_ctrl: request sequencer and output register valid for the range splitter
// depends on armp_pkg
module armp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  armp_pkg::armp_status_t status_i,
  output armp_pkg::armp_cmd_t    cmd_o
);

  armp_pkg::armp_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != armp_pkg::StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    case (state_q)
      armp_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = armp_pkg::StRun;
        end
      end
      armp_pkg::StRun: begin
        if (status_i.done) begin
          state_d = armp_pkg::StIdle;
        end else if (out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = armp_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= armp_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/armp_dp.sv @@
// armp_dp: piece datapath, slot counter, config registers and output payload
// depends on armp_pkg
module armp_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  armp_pkg::armp_cmd_t             cmd_i,
  output armp_pkg::armp_status_t          status_o,
  input  logic                            cfg_we_i,
  input  logic [armp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [armp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [armp_pkg::BaseInW-1:0]    range_base_i,
  input  logic [armp_pkg::SizeInW-1:0]    range_size_i,
  input  logic [armp_pkg::TypeW-1:0]      cache_type_i,
  input  logic                            restart_i,
  output logic [armp_pkg::SlotW-1:0]      slot_o,
  output logic [armp_pkg::WordW-1:0]      base_word_o,
  output logic [armp_pkg::WordW-1:0]      mask_word_o,
  output logic                            dropped_o,
  output logic                            into_reserved_o,
  output logic                            last_piece_o
);

  localparam int unsigned Rab = armp_pkg::RangeAddrBits;
  localparam int unsigned Rw  = armp_pkg::RemW;
  localparam int unsigned Ww  = armp_pkg::WordW;

  // config registers
  logic [armp_pkg::AbitsW-1:0] abits_q;
  logic [armp_pkg::TotalW-1:0] total_q;
  logic [armp_pkg::OsResW-1:0] osres_q;

  // working registers
  logic [Rab-1:0]                  base_q;
  logic [Rw-1:0]                   size_q;
  logic [armp_pkg::TypeW-1:0]      type_q;
  logic [armp_pkg::SlotW-1:0]      slot_q;
  logic [armp_pkg::CountW-1:0]     count_q;

  // output payload
  logic [armp_pkg::SlotW-1:0] slot_out_q;
  logic [Ww-1:0]              base_word_q, base_word_d;
  logic [Ww-1:0]              mask_word_q, mask_word_d;
  logic                       dropped_q, dropped_d;
  logic                       intores_q, intores_d;
  logic                       last_q, last_d;

  logic [Rab-1:0]                  in_base;
  logic [Rw-1:0]                   room;
  logic [Rw-1:0]                   load_size;
  logic [Rw-1:0]                   hi_oh;
  logic [Rw-1:0]                   lo_oh;
  logic [Rw-1:0]                   piece;
  logic [Rw-1:0]                   size_next;
  logic [Ww:0]                     piece_sh;
  logic [Ww:0]                     neg_full;
  logic [Ww-1:0]                   amask;
  logic [armp_pkg::TotalW-1:0]     total_eff;
  logic [armp_pkg::SlotW:0]        slot_plus_res;

  // clip the size to the top of the range space
  assign in_base = range_base_i[Rab-1:0];
  assign room    = {1'b1, {Rab{1'b0}}} - {1'b0, in_base};
  always_comb begin
    if (range_size_i > armp_pkg::SizeInW'(room)) begin
      load_size = room;
    end else begin
      load_size = range_size_i[Rw-1:0];
    end
  end

  // piece selection: alignment of base versus top bit of remainder
  assign hi_oh = armp_pkg::high_onehot(size_q);
  assign lo_oh = {1'b0, armp_pkg::low_onehot(base_q)};
  always_comb begin
    if ((base_q != '0) && (lo_oh <= hi_oh)) begin
      piece = lo_oh;
    end else begin
      piece = hi_oh;
    end
  end
  assign size_next = size_q - piece;

  // output words
  assign piece_sh = (Ww + 1)'(piece) << armp_pkg::PageShift;
  assign neg_full = (Ww + 1)'(0) - piece_sh;

  always_comb begin
    for (int i = 0; i < Ww; i++) begin
      amask[i] = (armp_pkg::AbitsW'(i) < abits_q);
    end
  end

  assign total_eff     = (total_q > armp_pkg::SlotStore) ? armp_pkg::SlotStore : total_q;
  assign slot_plus_res = {1'b0, slot_q} + (armp_pkg::SlotW + 1)'(osres_q);

  always_comb begin
    base_word_d = (Ww'(base_q) << armp_pkg::PageShift) | Ww'(type_q);
    mask_word_d = (neg_full[Ww-1:0] & amask) | armp_pkg::MaskValid;
    dropped_d   = (slot_q >= armp_pkg::SlotW'(total_eff));
    intores_d   = !dropped_d && (slot_plus_res >= (armp_pkg::SlotW + 1)'(total_eff));
    last_d      = (size_next == '0);
  end

  assign status_o.done = (size_q == '0) || (count_q == armp_pkg::CountW'(armp_pkg::MaxPieces));

  // control-like state: config, slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abits_q <= armp_pkg::AbitsReset;
      total_q <= armp_pkg::TotalReset;
      osres_q <= armp_pkg::OsResReset;
      slot_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          armp_pkg::CfgAddressBits: abits_q <= cfg_data_i[armp_pkg::AbitsW-1:0];
          armp_pkg::CfgTotalSlots:  total_q <= cfg_data_i[armp_pkg::TotalW-1:0];
          armp_pkg::CfgOsReserved:  osres_q <= cfg_data_i[armp_pkg::OsResW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.load && restart_i) begin
        slot_q <= '0;
      end else if (cmd_i.step && (slot_q != armp_pkg::SlotMax)) begin
        slot_q <= slot_q + armp_pkg::SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.load) begin
      size_q  <= load_size;
      count_q <= '0;
    end else if (cmd_i.step) begin
      size_q  <= size_next;
      count_q <= count_q + armp_pkg::CountW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= in_base;
      type_q <= cache_type_i;
    end else if (cmd_i.step) begin
      base_q <= base_q + piece[Rab-1:0];
    end
    if (cmd_i.step) begin
      slot_out_q  <= slot_q;
      base_word_q <= base_word_d;
      mask_word_q <= mask_word_d;
      dropped_q   <= dropped_d;
      intores_q   <= intores_d;
      last_q      <= last_d;
    end
  end

  assign slot_o          = slot_out_q;
  assign base_word_o     = base_word_q;
  assign mask_word_o     = mask_word_q;
  assign dropped_o       = dropped_q;
  assign into_reserved_o = intores_q;
  assign last_piece_o    = last_q;

endmodule

@@ hdl/aligned_range_to_mtrr_pairs.sv @@
// aligned_range_to_mtrr_pairs: top level, splits one range request into aligned pieces
// depends on armp_pkg, armp_ctrl, armp_dp
// flow: a taken request loads the working registers, then each piece is registered
// throughput: one piece a cycle from the piece unit while the output register is free;
//   the input stays stalled until the sequencer is back in idle, also for zero size
// reset: asynchronous active low; clears sequencer, slot counter and config registers
module aligned_range_to_mtrr_pairs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // range request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [armp_pkg::BaseInW-1:0]    range_base_i,
  input  logic [armp_pkg::SizeInW-1:0]    range_size_i,
  input  logic [armp_pkg::TypeW-1:0]      cache_type_i,
  input  logic                            restart_i,
  // piece channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [armp_pkg::SlotW-1:0]      slot_o,
  output logic [armp_pkg::WordW-1:0]      base_word_o,
  output logic [armp_pkg::WordW-1:0]      mask_word_o,
  output logic                            dropped_o,
  output logic                            into_reserved_o,
  output logic                            last_piece_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [armp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [armp_pkg::CfgDataW-1:0]   cfg_data_i
);

  armp_pkg::armp_cmd_t    cmd;
  armp_pkg::armp_status_t status;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: idle takes a request, run emits one piece whenever the output register
  // is free, and returns to idle once the remainder is gone or the piece limit is hit
  armp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: clipping, piece choice, word build, slot flags, output register
  armp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .range_base_i    (range_base_i),
    .range_size_i    (range_size_i),
    .cache_type_i    (cache_type_i),
    .restart_i       (restart_i),
    .slot_o          (slot_o),
    .base_word_o     (base_word_o),
    .mask_word_o     (mask_word_o),
    .dropped_o       (dropped_o),
    .into_reserved_o (into_reserved_o),
    .last_piece_o    (last_piece_o)
  );

  // a taken request keeps the input stalled in the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a range request was taken");

  // a dropped piece is never flagged as reserved
  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(dropped_o && into_reserved_o))
    else $error("piece flagged both dropped and reserved");

  // stored slots lie within the register file
  a_slot_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !dropped_o) |-> (slot_o < armp_pkg::SlotW'(16)))
    else $error("stored slot beyond register file");

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for aligned_range_to_mtrr_pairs
// holds its own piece predictor, randomised range stimulus and handshake idling
// depends on armp_pkg and the aligned_range_to_mtrr_pairs rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // run length and pacing
  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 70;
  localparam int HoldCycles   = 400;  // long receiver hold-off
  localparam int RandomRanges = 160;
  localparam int CalmTail     = 40;   // last random ranges run with no idling
  localparam logic [63:0] RangeTop = 64'd1 << armp_pkg::RangeAddrBits;

  // one expected register pair
  typedef struct packed {
    logic [armp_pkg::SlotW-1:0] slot;
    logic [armp_pkg::WordW-1:0] base_word;
    logic [armp_pkg::WordW-1:0] mask_word;
    logic                       dropped;
    logic                       into_reserved;
    logic                       last_piece;
  } mtrr_pair_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // range request channel
  logic                            in_valid_i   = 1'b0;
  logic                            in_stall_o;
  logic [armp_pkg::BaseInW-1:0]    range_base_i = '0;
  logic [armp_pkg::SizeInW-1:0]    range_size_i = '0;
  logic [armp_pkg::TypeW-1:0]      cache_type_i = '0;
  logic                            restart_i    = 1'b0;
  // piece channel
  logic                            out_valid_o;
  logic                            out_stall_i  = 1'b0;
  logic [armp_pkg::SlotW-1:0]      slot_o;
  logic [armp_pkg::WordW-1:0]      base_word_o;
  logic [armp_pkg::WordW-1:0]      mask_word_o;
  logic                            dropped_o;
  logic                            into_reserved_o;
  logic                            last_piece_o;
  // register write channel
  logic                            cfg_valid_i  = 1'b0;
  logic                            cfg_ready_o;
  logic [armp_pkg::CfgIdxW-1:0]    cfg_index_i  = '0;
  logic [armp_pkg::CfgDataW-1:0]   cfg_data_i   = '0;

  // predictor copy of the registers and the slot counter
  logic [armp_pkg::AbitsW-1:0]  abits_reg   = armp_pkg::AbitsReset;
  logic [armp_pkg::TotalW-1:0]  total_reg   = armp_pkg::TotalReset;
  logic [armp_pkg::OsResW-1:0]  osres_reg   = armp_pkg::OsResReset;
  logic [armp_pkg::SlotW-1:0]   next_slot   = '0;

  mtrr_pair_t pairs_due[$];   // pieces still to come, oldest first
  int mismatches = 0;
  int cycle_count = 0;

  // idling controls, written by the test sequence only
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int hold_asks = 0;

  // receiver-side state
  int hold_served = 0;
  int hold_left = 0;
  int burst_left = 0;

  aligned_range_to_mtrr_pairs dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .range_base_i    (range_base_i),
    .range_size_i    (range_size_i),
    .cache_type_i    (cache_type_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .slot_o          (slot_o),
    .base_word_o     (base_word_o),
    .mask_word_o     (mask_word_o),
    .dropped_o       (dropped_o),
    .into_reserved_o (into_reserved_o),
    .last_piece_o    (last_piece_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d pieces outstanding", cycle_count,
               pairs_due.size());
      $display("aligned_range_to_mtrr_pairs test failed");
      $finish;
    end
  end

  // splits one accepted range into the pieces the block should emit, in order,
  // and advances the slot counter the same way
  task automatic split_range(input logic [armp_pkg::BaseInW-1:0] rbase,
                             input logic [armp_pkg::SizeInW-1:0] rsize,
                             input logic [armp_pkg::TypeW-1:0]   ctype,
                             input logic                         clear_slots);
    logic [63:0] cur_base;
    logic [63:0] remain;
    logic [63:0] piece;
    logic [63:0] amask;
    int unsigned top_bit;
    int unsigned base_lsb;
    int unsigned shift;
    int usable;
    int os_edge;
    int taken;
    mtrr_pair_t p;
    cur_base = 64'(rbase);
    remain   = 64'(rsize);
    amask    = (64'd1 << abits_reg) - 64'd1;
    // anything above sixteen pairs counts as sixteen
    usable   = (total_reg > armp_pkg::SlotStore) ? int'(armp_pkg::SlotStore) : int'(total_reg);
    // may go negative when the reserve is larger than the pair count
    os_edge  = usable - int'(osres_reg);
    taken    = 0;
    if (clear_slots) next_slot = '0;
    // clip so the range never runs past the top of the range space
    if (remain > RangeTop - cur_base) remain = RangeTop - cur_base;
    while (remain != 64'd0 && taken < armp_pkg::MaxPieces) begin
      top_bit = 63;
      while (top_bit > 0 && !remain[top_bit]) top_bit--;
      shift = top_bit;
      // a zero base imposes no alignment limit
      if (cur_base != 64'd0) begin
        base_lsb = 0;
        while (base_lsb < 63 && !cur_base[base_lsb]) base_lsb++;
        if (base_lsb <= top_bit) shift = base_lsb;
      end
      piece = 64'd1 << shift;
      p.slot          = next_slot;
      p.base_word     = 40'((cur_base << armp_pkg::PageShift) | 64'(ctype));
      p.mask_word     = 40'(((64'd0 - (piece << armp_pkg::PageShift)) & amask) | 64'h800);
      p.dropped       = int'(next_slot) >= usable;
      p.into_reserved = !p.dropped && int'(next_slot) >= os_edge;
      remain   = remain - piece;
      cur_base = cur_base + piece;
      p.last_piece    = (remain == 64'd0);
      pairs_due.push_back(p);
      // counter sticks at its top value
      if (next_slot != armp_pkg::SlotMax) next_slot = next_slot + 1'b1;
      taken++;
    end
  endtask

  // offers one range request and waits until the block takes it; valid stays
  // high afterwards so a back-to-back request needs no second assignment
  task automatic send_range(input logic [armp_pkg::BaseInW-1:0] rbase,
                            input logic [armp_pkg::SizeInW-1:0] rsize,
                            input logic [armp_pkg::TypeW-1:0]   ctype,
                            input logic                         clear_slots);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    range_base_i <= rbase;
    range_size_i <= rsize;
    cache_type_i <= ctype;
    restart_i    <= clear_slots;
    do @(posedge clk_i); while (in_stall_o);
    split_range(rbase, rsize, ctype, clear_slots);
  endtask

  // drops valid and waits for every expected piece, then lets the block settle
  // (a zero size range may still be in flight when the queue empties)
  task automatic drain_pieces(input int settle);
    in_valid_i <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // writes all three registers back to back, only ever with the block idle
  task automatic apply_settings(input logic [armp_pkg::CfgDataW-1:0] abits,
                                input logic [armp_pkg::CfgDataW-1:0] total,
                                input logic [armp_pkg::CfgDataW-1:0] osres);
    logic [armp_pkg::CfgIdxW-1:0]  idx  [3];
    logic [armp_pkg::CfgDataW-1:0] data [3];
    drain_pieces(SettleCycles);
    idx[0] = armp_pkg::CfgAddressBits;  data[0] = abits;
    idx[1] = armp_pkg::CfgTotalSlots;   data[1] = total;
    idx[2] = armp_pkg::CfgOsReserved;   data[2] = osres;
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        armp_pkg::CfgAddressBits: abits_reg = data[i];
        armp_pkg::CfgTotalSlots:  total_reg = data[i][armp_pkg::TotalW-1:0];
        armp_pkg::CfgOsReserved:  osres_reg = data[i][armp_pkg::OsResW-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stall bursts, plus a long hold-off when the sequence asks
  always @(posedge clk_i) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (rx_idle && $urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [armp_pkg::WordW-1:0] want,
                             input logic [armp_pkg::WordW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // every piece taken from the block is matched against the oldest expectation
  always @(posedge clk_i) begin
    mtrr_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pairs_due.size() == 0) begin
        $display("%0t: unexpected piece, expected none, actual slot 0x%0h base 0x%0h",
                 $time, slot_o, base_word_o);
        mismatches++;
      end else begin
        want = pairs_due.pop_front();
        check_field("slot", 40'(want.slot), 40'(slot_o));
        check_field("base_word", want.base_word, base_word_o);
        check_field("mask_word", want.mask_word, mask_word_o);
        check_field("dropped", 40'(want.dropped), 40'(dropped_o));
        check_field("into_reserved", 40'(want.into_reserved), 40'(into_reserved_o));
        check_field("last_piece", 40'(want.last_piece), 40'(last_piece_o));
      end
    end
  end

  // corners at the reset register values: zero size, whole space from zero,
  // clipping at the top, alternating bit patterns, every cache type
  task automatic test_range_corners();
    send_range(28'h0000000, 29'h0000000, 3'd0, 1'b1);   // zero size, no pieces
    send_range(28'h0000000, 29'h10000000, 3'd7, 1'b0);  // zero base, whole space
    send_range(28'hFFFFFFF, 29'h1FFFFFFF, 3'd5, 1'b0);  // clipped to one unit
    send_range(28'h0000001, 29'h0FFFFFFF, 3'd1, 1'b1);  // ascending run to the top
    send_range(28'h5555555, 29'h0AAAAAAA, 3'd2, 1'b0);
    send_range(28'hAAAAAAA, 29'h05555555, 3'd3, 1'b1);
    send_range(28'h0000000, 29'h1FFFFFFF, 3'd4, 1'b1);  // oversize from zero
    send_range(28'h8000000, 29'h08000000, 3'd6, 1'b0);
    send_range(28'h0000100, 29'h00000300, 3'd3, 1'b1);
    send_range(28'h0001000, 29'h00000001, 3'd2, 1'b0);
    send_range(28'h0000003, 29'h0000000D, 3'd0, 1'b0);
    send_range(28'hFFFFFFF, 29'h00000000, 3'd7, 1'b1);  // zero size at top
  endtask

  // register extremes: narrow and wide masks, no pairs, more than sixteen,
  // reserve larger than the pair count, upper data bits that are cut off
  task automatic test_register_extremes();
    logic [armp_pkg::CfgDataW-1:0] settings [6][3];
    settings[0] = '{6'd32, 6'd0,  6'd0};
    settings[1] = '{6'd40, 6'd16, 6'd2};
    settings[2] = '{6'd0,  6'd31, 6'd3};
    settings[3] = '{6'd63, 6'd17, 6'd1};
    settings[4] = '{6'd36, 6'd2,  6'd3};
    settings[5] = '{6'd33, 6'h25, 6'h3E};
    for (int s = 0; s < 6; s++) begin
      apply_settings(settings[s][0], settings[s][1], settings[s][2]);
      send_range(28'h0000001, 29'h0FFFFFFF, 3'(s), 1'b1);
      send_range(28'h0000000, 29'h10000000, 3'(s + 1), 1'b0);
      send_range(28'(s * 28'h123457), 29'h00FFFFFF, 3'(s + 2), 1'b0);
    end
  endtask

  // slot counter runs up to its top and stays there until a restart
  task automatic test_slot_saturation();
    apply_settings(6'd36, 6'd16, 6'd2);
    send_range(28'h0000001, 29'h0FFFFFFF, 3'd6, 1'b1);
    for (int i = 0; i < 5; i++) send_range(28'h0000001, 29'h0FFFFFFF, 3'(i), 1'b0);
    send_range(28'h0000400, 29'h00000C00, 3'd1, 1'b1);
  endtask

  // the receiver holds off long enough for the block to back up onto its input,
  // then the sender pauses until the pipe is empty before carrying on
  task automatic test_backpressure();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_asks++;
    for (int i = 0; i < 6; i++)
      send_range(28'($urandom), 29'($urandom_range(1, 1 << 20)), 3'($urandom), 1'(i == 0));
    drain_pieces(0);
    for (int i = 0; i < 4; i++)
      send_range(28'($urandom), 29'($urandom), 3'($urandom), 1'b0);
  endtask

  // random ranges across random register settings; the tail runs flat out
  task automatic test_random_ranges();
    logic [armp_pkg::BaseInW-1:0] rbase;
    logic [armp_pkg::SizeInW-1:0] rsize;
    logic [armp_pkg::CfgDataW-1:0] abits;
    for (int n = 0; n < RandomRanges; n++) begin
      if (n % 50 == 0) begin
        abits = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(32, 40));
        apply_settings(abits, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      end
      if (n == RandomRanges - CalmTail) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: rbase = 28'($urandom);
        1: rbase = 28'($urandom_range(0, 255)) << $urandom_range(0, 27);
        2: rbase = 28'($urandom_range(0, 4095));
        default: rbase = 28'hFFFFFFF - 28'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 9))
        0, 1: rsize = 29'($urandom);
        2, 3: rsize = 29'($urandom_range(1, 1024));
        4, 5: rsize = 29'd1 << $urandom_range(0, 28);
        6:    rsize = '0;
        default: rsize = 29'($urandom >> $urandom_range(3, 28));
      endcase
      send_range(rbase, rsize, 3'($urandom), 1'($urandom_range(0, 4) == 0));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_range_corners();
    test_register_extremes();
    test_slot_saturation();
    test_backpressure();
    test_random_ranges();
    drain_pieces(SettleCycles);
    if (mismatches == 0) begin
      $display("aligned_range_to_mtrr_pairs test passed");
    end else begin
      $display("aligned_range_to_mtrr_pairs test failed");
    end
    $finish;
  end

endmodule
